@@ hw/rtl/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SMAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define SMAM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/smam_pkg.sv @@
// types and constants for the sparse matrix add merge block
// no dependencies; imported by the top level and its checker
package smam_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_RUN         = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [15:0]        term_row;
    logic [15:0]        term_column;
    logic signed [31:0] term_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic [15:0]        out_column;
    logic signed [31:0] out_value;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_word_t;

  // one stored list entry: row, column, value
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] column;
    logic [31:0] value;
  } term_t;

endpackage

@@ hw/rtl/sparse_matrix_add_merge.sv @@
// Sparse matrix addition by coordinate-list merge. Load words (mode 0 or 1)
// append one term to the first or second list, taken one per cycle when idle;
// a load into a full list (32 terms) is dropped and sets the overflow flag
// carried on the next run's results. A run word (mode 2) merges the two lists
// in row-major order through one shared compare and add unit and emits one
// word per result term, the final one marked last, then empties both lists.
// Each result passes through S_READ, for the list memory read, then S_EMIT,
// for the compare and add, where out_stall can hold the output register. A run
// with both lists empty emits one empty_res word. in_stall is high for the whole
// run; mode 3 is accepted and ignored.
// depends on smam_pkg
module sparse_matrix_add_merge
  import smam_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic       dropped_r, dropped_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  logic       out_load;

  term_t      mem_a_r [LIST_DEPTH];
  term_t      mem_b_r [LIST_DEPTH];
  term_t      rd_a_r, rd_b_r;

  logic       in_acc, wr_a, wr_b;
  term_t      wr_term;

  // shared merge unit signals
  logic        a_ok, b_ok, take_a, take_b;
  logic [31:0] key_a, key_b, key_sel, sum;
  logic [CNT_W-1:0] i_step, j_step;
  logic        is_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_term  = '{row: in_data.term_row, column: in_data.term_column,
                      value: in_data.term_value};
  assign wr_a = in_acc && (in_data.mode == MODE_LOAD_FIRST)
                && (cnt_a_r < CNT_W'(LIST_DEPTH));
  assign wr_b = in_acc && (in_data.mode == MODE_LOAD_SECOND)
                && (cnt_b_r < CNT_W'(LIST_DEPTH));

  // list memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a_r[cnt_a_r[IDX_W-1:0]] <= wr_term;
    end
    if (wr_b) begin
      mem_b_r[cnt_b_r[IDX_W-1:0]] <= wr_term;
    end
    rd_a_r <= mem_a_r[i_r[IDX_W-1:0]];
    rd_b_r <= mem_b_r[j_r[IDX_W-1:0]];
  end

  // compare the two heads and add where coordinates match
  always_comb begin
    a_ok   = (i_r < cnt_a_r);
    b_ok   = (j_r < cnt_b_r);
    key_a  = {rd_a_r.row, rd_a_r.column};
    key_b  = {rd_b_r.row, rd_b_r.column};
    take_a = a_ok && (!b_ok || (key_a <= key_b));
    take_b = b_ok && (!a_ok || (key_b <= key_a));
    key_sel = take_a ? key_a : (take_b ? key_b : 32'd0);
    sum    = (take_a ? rd_a_r.value : 32'd0) + (take_b ? rd_b_r.value : 32'd0);
    i_step = i_r + CNT_W'(take_a);
    j_step = j_r + CNT_W'(take_b);
    is_last = !((i_step < cnt_a_r) || (j_step < cnt_b_r));
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    dropped_nxt  = dropped_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            MODE_LOAD_FIRST: begin
              if (wr_a) cnt_a_nxt = cnt_a_r + CNT_W'(1);
              else dropped_nxt = 1'b1;
            end
            MODE_LOAD_SECOND: begin
              if (wr_b) cnt_b_nxt = cnt_b_r + CNT_W'(1);
              else dropped_nxt = 1'b1;
            end
            MODE_RUN: begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      // heads are being read from the list memories
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load               = 1'b1;
          out_data_nxt.out_row    = key_sel[31:16];
          out_data_nxt.out_column = key_sel[15:0];
          out_data_nxt.out_value  = sum;
          out_data_nxt.last       = is_last;
          out_data_nxt.empty_res  = !a_ok && !b_ok;
          out_data_nxt.overflow   = dropped_r;
          i_nxt = i_step;
          j_nxt = j_step;
          if (is_last) begin
            state_nxt   = S_IDLE;
            cnt_a_nxt   = '0;
            cnt_b_nxt   = '0;
            dropped_nxt = 1'b0;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/smam_checker.sv @@
// port-level checks for sparse_matrix_add_merge, bound to the top level
// depends on smam_pkg and assert_macros.svh
`include "assert_macros.svh"

module smam_checker
  import smam_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic in_acc;
  logic empty_zero;
  assign in_acc = in_valid && !in_stall;
  assign empty_zero = (out_data.out_row == 16'd0) && (out_data.out_column == 16'd0)
                      && (out_data.out_value == 32'sd0);

  `SMAM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SMAM_ASSERT_IMP(a_empty_last, out_valid && out_data.empty_res, out_data.last)
  `SMAM_ASSERT_IMP(a_empty_zero, out_valid && out_data.empty_res, empty_zero)
  `SMAM_ASSERT_NXT(a_run_busy, in_acc && (in_data.mode == MODE_RUN), in_stall)
  `SMAM_ASSERT_NXT(a_load_quiet, in_acc && (in_data.mode != MODE_RUN) && !out_valid, !out_valid)

endmodule

bind sparse_matrix_add_merge smam_checker u_smam_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for sparse_matrix_add_merge: loads term lists, runs merges
// and compares every emitted sum term against a merge predictor kept in step here
// depends on smam_pkg and the sparse_matrix_add_merge rtl
module tb_top;
  import smam_pkg::*;

  localparam mode_t MODE_UNUSED = mode_t'(2'd3);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int TARGET_WORDS = 330;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // words waiting to be driven, expected merge output
  in_word_t  term_word_q[$];
  out_word_t merge_expect_q[$];

  // predictor state
  term_t first_terms[LIST_DEPTH];
  term_t second_terms[LIST_DEPTH];
  int    first_cnt = 0;
  int    second_cnt = 0;
  logic  dropped = 1'b0;

  int   mismatch_count = 0;
  int   word_total = 0;
  int   cycle_count = 0;
  logic in_fire = 1'b0;

  sparse_matrix_add_merge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic in_word_t make_word(mode_t m, logic [31:0] key, logic [31:0] val);
    in_word_t w;
    w.mode        = m;
    w.term_row    = key[31:16];
    w.term_column = key[15:0];
    w.term_value  = val;
    return w;
  endfunction

  function automatic void queue_word(in_word_t w);
    term_word_q.push_back(w);
    if (w.mode != MODE_UNUSED) word_total++;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // packed {row, column}; near keys crowd a small corner so coordinates collide
  function automatic logic [31:0] random_key(bit near);
    if (near) return {16'($urandom_range(0, 7)), 16'($urandom_range(0, 7))};
    return $urandom;
  endfunction

  // two row-major lists, partly sharing coordinates, loaded interleaved, then a run
  function automatic void queue_merge_case(int n1, int n2, bit near);
    logic [31:0] keys_a[$];
    logic [31:0] keys_b[$];
    int ia;
    int ib;
    for (int k = 0; k < n1; k++) keys_a.push_back(random_key(near));
    for (int k = 0; k < n2; k++) begin
      if (keys_a.size() > 0 && $urandom_range(0, 1))
        keys_b.push_back(keys_a[$urandom_range(0, keys_a.size() - 1)]);
      else
        keys_b.push_back(random_key(near));
    end
    keys_a.sort();
    keys_b.sort();
    ia = 0;
    ib = 0;
    while (ia < n1 || ib < n2) begin
      if (ib >= n2 || (ia < n1 && $urandom_range(0, 1))) begin
        queue_word(make_word(MODE_LOAD_FIRST, keys_a[ia], random_value()));
        ia++;
      end else begin
        queue_word(make_word(MODE_LOAD_SECOND, keys_b[ib], random_value()));
        ib++;
      end
    end
    queue_word(make_word(MODE_RUN, $urandom, $urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: updates the lists and queues the results a word causes

  function automatic void predict_word(in_word_t w);
    term_t       t;
    out_word_t   r;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] key;
    logic [31:0] sum;
    int          i;
    int          j;
    t.row    = w.term_row;
    t.column = w.term_column;
    t.value  = w.term_value;
    case (w.mode)
      MODE_LOAD_FIRST: begin
        if (first_cnt >= LIST_DEPTH) begin
          dropped = 1'b1;
        end else begin
          first_terms[first_cnt] = t;
          first_cnt++;
        end
      end
      MODE_LOAD_SECOND: begin
        if (second_cnt >= LIST_DEPTH) begin
          dropped = 1'b1;
        end else begin
          second_terms[second_cnt] = t;
          second_cnt++;
        end
      end
      MODE_RUN: begin
        if (first_cnt == 0 && second_cnt == 0) begin
          r = '0;
          r.last      = 1'b1;
          r.empty_res = 1'b1;
          r.overflow  = dropped;
          merge_expect_q.push_back(r);
        end
        i = 0;
        j = 0;
        while (i < first_cnt || j < second_cnt) begin
          r = '0;
          if (i < first_cnt && j < second_cnt) begin
            ka = {first_terms[i].row, first_terms[i].column};
            kb = {second_terms[j].row, second_terms[j].column};
            if (ka == kb) begin
              key = ka;
              sum = first_terms[i].value + second_terms[j].value;
              i++;
              j++;
            end else if (ka < kb) begin
              key = ka;
              sum = first_terms[i].value;
              i++;
            end else begin
              key = kb;
              sum = second_terms[j].value;
              j++;
            end
          end else if (i < first_cnt) begin
            key = {first_terms[i].row, first_terms[i].column};
            sum = first_terms[i].value;
            i++;
          end else begin
            key = {second_terms[j].row, second_terms[j].column};
            sum = second_terms[j].value;
            j++;
          end
          r.out_row    = key[31:16];
          r.out_column = key[15:0];
          r.out_value  = sum;
          r.last       = !(i < first_cnt || j < second_cnt);
          r.overflow   = dropped;
          merge_expect_q.push_back(r);
        end
        first_cnt  = 0;
        second_cnt = 0;
        dropped    = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of words with random gaps, changes only at the falling edge

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (term_word_q.size() > 0) begin
        in_data  <= term_word_q.pop_front();
        in_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: phases of none, light, half and heavy back-pressure
  int stall_style = 0;
  int stall_phase_left = 0;

  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_style      = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 80);
    end else begin
      stall_phase_left = stall_phase_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: sample handshakes at the rising edge

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (merge_expect_q.size() == 0) begin
          mismatch_count++;
          $display("%0t mismatch expected: no word", $time);
          $display("%0t mismatch actual:   row %h col %h value %h last %b empty %b ovf %b",
                   $time, out_data.out_row, out_data.out_column, out_data.out_value,
                   out_data.last, out_data.empty_res, out_data.overflow);
        end else begin
          out_word_t want;
          want = merge_expect_q.pop_front();
          if (out_data.out_row !== want.out_row || out_data.out_column !== want.out_column ||
              out_data.out_value !== want.out_value || out_data.last !== want.last ||
              out_data.empty_res !== want.empty_res || out_data.overflow !== want.overflow) begin
            mismatch_count++;
            $display("%0t mismatch expected: row %h col %h value %h last %b empty %b ovf %b",
                     $time, want.out_row, want.out_column, want.out_value,
                     want.last, want.empty_res, want.overflow);
            $display("%0t mismatch actual:   row %h col %h value %h last %b empty %b ovf %b",
                     $time, out_data.out_row, out_data.out_column, out_data.out_value,
                     out_data.last, out_data.empty_res, out_data.overflow);
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words still expected", $time, merge_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run

  initial begin
    // run on two empty lists
    queue_word(make_word(MODE_RUN, 32'h0, 32'h0));
    // extremes, a wrapped sum on both ends, smaller column and smaller row picks
    queue_word(make_word(MODE_LOAD_FIRST, 32'h0000_0000, 32'h8000_0000));
    queue_word(make_word(MODE_LOAD_FIRST, 32'h0000_0005, 32'h0000_0001));
    queue_word(make_word(MODE_LOAD_FIRST, 32'hffff_ffff, 32'h7fff_ffff));
    queue_word(make_word(MODE_LOAD_SECOND, 32'h0000_0000, 32'hffff_ffff));
    queue_word(make_word(MODE_LOAD_SECOND, 32'h0000_0003, 32'h0000_000a));
    queue_word(make_word(MODE_LOAD_SECOND, 32'h0001_0000, 32'h0000_0005));
    queue_word(make_word(MODE_LOAD_SECOND, 32'hffff_ffff, 32'h0000_0001));
    // unused mode leaves the lists alone
    queue_word(make_word(MODE_UNUSED, $urandom, $urandom));
    queue_word(make_word(MODE_RUN, 32'hffff_ffff, 32'hffff_ffff));
    // only the second list, out of order
    queue_word(make_word(MODE_LOAD_SECOND, 32'h0007_0007, 32'h1234_5678));
    queue_word(make_word(MODE_LOAD_SECOND, 32'h0002_0002, 32'h8765_4321));
    queue_word(make_word(MODE_RUN, $urandom, $urandom));
    // only the first list
    queue_word(make_word(MODE_LOAD_FIRST, 32'h0003_0001, 32'hdead_beef));
    queue_word(make_word(MODE_LOAD_FIRST, 32'h0003_0000, 32'h0000_0000));
    queue_word(make_word(MODE_RUN, 32'h0, 32'h0));

    while (word_total < TARGET_WORDS - 15) begin
      if ($urandom_range(0, 3) != 0) begin
        int n1;
        int n2;
        // mostly small lists, now and then one near or past full
        n1 = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        n2 = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        queue_merge_case(n1, n2, $urandom_range(0, 3) != 0);
      end else begin
        // noise: any mode, any fields, lists left unordered
        repeat ($urandom_range(1, 6))
          queue_word(make_word(mode_t'($urandom_range(0, 3)), random_key($urandom_range(0, 1)),
                               random_value()));
      end
    end
    queue_word(make_word(MODE_RUN, $urandom, $urandom));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (term_word_q.size() != 0 || in_valid) @(posedge clk);
    while (merge_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && merge_expect_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/smam_pkg.sv
hw/rtl/sparse_matrix_add_merge.sv
hw/rtl/smam_checker.sv
bench/tb_top.sv
